// File: design/hcsf_pkg.sv
`timescale 1ns / 1ps
package hcsf_pkg;

  localparam int H_W         = 32;
  localparam int SUM_W       = 34;
  localparam int MAG_W       = 34;
  localparam int HALF_W      = 17;
  localparam int PP_W        = 2 * HALF_W;
  localparam int SQR_W       = 68;
  localparam int X1_W        = 78;
  localparam int X1_SH       = 18;
  localparam int X2_SH       = 30;
  localparam int SQ_IN_W     = 98;
  localparam int SQ_STAGES   = 49;
  localparam int ROOT_W      = 49;
  localparam int REM_W       = 51;
  localparam int SLOPE_W     = 24;
  localparam int DIV_STAGES  = 24;
  localparam int FALL_Q_W    = 15;
  localparam int NUM_W       = 64;
  localparam int NUM_SH      = NUM_W - MAG_W;
  localparam int FALL_W      = 16;
  localparam int CS_W        = 16;
  localparam int DIR_LIM_W   = 15;
  localparam int MICRO_W     = 20;
  localparam int BIG_W       = DIR_LIM_W + MICRO_W;
  localparam int THR_W       = 2 * CS_W + 2;
  localparam int CORNERS     = 4;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;
  localparam int FIFO_CW     = 3;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_USED_W  = SLOPE_W + 1 + 2 * FALL_W;

  localparam logic [CS_W-1:0]    CS_RESET     = 16'd1600;
  localparam logic [MICRO_W-1:0] MICRO        = 20'd1000000;
  localparam logic [SLOPE_W-1:0] SLOPE_MAX    = 24'hFFFFFF;
  localparam logic [FALL_W-1:0]  FALL_FULL    = 16'h8000;
  localparam logic [FALL_W-1:0]  FALL_POS_MAX = 16'h7FFF;

  typedef struct packed {
    logic signed [H_W-1:0] h00;
    logic signed [H_W-1:0] h10;
    logic signed [H_W-1:0] h01;
    logic signed [H_W-1:0] h11;
    logic [CORNERS-1:0]    corner_invalid;
    logic                  in_green;
  } hcsf_in_t;

  typedef struct packed {
    logic             inv;
    logic             green;
    logic             sx_neg;
    logic             sy_neg;
    logic [MAG_W-1:0] ux;
    logic [MAG_W-1:0] uy;
    logic [SQR_W-1:0] s2;
  } hcsf_cell_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hcsf_fifo_st_t;

  typedef struct packed {
    logic                     in_green;
    logic [SLOPE_W-1:0]       slope;
    logic                     has_dir;
    logic signed [FALL_W-1:0] fall_x;
    logic signed [FALL_W-1:0] fall_y;
  } hcsf_out_t;

endpackage

// File: design/hcsf_front.sv
`timescale 1ns / 1ps
module hcsf_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hcsf_pkg::hcsf_in_t    in_i,
  input  hcsf_pkg::hcsf_fifo_st_t fifo_st_i,
  output logic                  push_o,
  output hcsf_pkg::hcsf_cell_t  cell_o
);
  import hcsf_pkg::*;

  logic en;
  logic [4:0] v_q;

  logic signed [SUM_W-1:0] sx0_q, sy0_q;
  logic inv0_q, green0_q;

  logic [MAG_W-1:0] ux1_q, uy1_q, ux2_q, uy2_q, ux3_q, uy3_q, ux4_q, uy4_q;
  logic [3:0] fl1_q, fl2_q, fl3_q, fl4_q;

  logic [PP_W-1:0] xhh2_q, xhl2_q, xll2_q, yhh2_q, yhl2_q, yll2_q;
  logic [SQR_W-1:0] xsq3_q, ysq3_q, s2_4_q;

  logic signed [SUM_W-1:0] sx_d, sy_d;

  assign en         = !v_q[4] || !fifo_st_i.full;
  assign in_ready_o = en;
  assign push_o     = v_q[4] && !fifo_st_i.full;

  assign sx_d = (SUM_W'(in_i.h10) + SUM_W'(in_i.h11)) - (SUM_W'(in_i.h00) + SUM_W'(in_i.h01));
  assign sy_d = (SUM_W'(in_i.h01) + SUM_W'(in_i.h11)) - (SUM_W'(in_i.h00) + SUM_W'(in_i.h10));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[3:0], in_valid_i};
    end
  end

  // flags: {inv, green, sx_neg, sy_neg}
  always_ff @(posedge clk_i) begin
    if (en) begin
      sx0_q    <= sx_d;
      sy0_q    <= sy_d;
      inv0_q   <= |in_i.corner_invalid;
      green0_q <= in_i.in_green;

      ux1_q <= MAG_W'(sx0_q[SUM_W-1] ? -sx0_q : sx0_q);
      uy1_q <= MAG_W'(sy0_q[SUM_W-1] ? -sy0_q : sy0_q);
      fl1_q <= {inv0_q, green0_q, sx0_q[SUM_W-1], sy0_q[SUM_W-1]};

      xhh2_q <= PP_W'(ux1_q[MAG_W-1:HALF_W]) * PP_W'(ux1_q[MAG_W-1:HALF_W]);
      xhl2_q <= PP_W'(ux1_q[MAG_W-1:HALF_W]) * PP_W'(ux1_q[HALF_W-1:0]);
      xll2_q <= PP_W'(ux1_q[HALF_W-1:0]) * PP_W'(ux1_q[HALF_W-1:0]);
      yhh2_q <= PP_W'(uy1_q[MAG_W-1:HALF_W]) * PP_W'(uy1_q[MAG_W-1:HALF_W]);
      yhl2_q <= PP_W'(uy1_q[MAG_W-1:HALF_W]) * PP_W'(uy1_q[HALF_W-1:0]);
      yll2_q <= PP_W'(uy1_q[HALF_W-1:0]) * PP_W'(uy1_q[HALF_W-1:0]);
      ux2_q  <= ux1_q;
      uy2_q  <= uy1_q;
      fl2_q  <= fl1_q;

      xsq3_q <= (SQR_W'(xhh2_q) << PP_W) + (SQR_W'(xhl2_q) << (HALF_W + 1)) + SQR_W'(xll2_q);
      ysq3_q <= (SQR_W'(yhh2_q) << PP_W) + (SQR_W'(yhl2_q) << (HALF_W + 1)) + SQR_W'(yll2_q);
      ux3_q  <= ux2_q;
      uy3_q  <= uy2_q;
      fl3_q  <= fl2_q;

      s2_4_q <= xsq3_q + ysq3_q;
      ux4_q  <= ux3_q;
      uy4_q  <= uy3_q;
      fl4_q  <= fl3_q;
    end
  end

  always_comb begin
    cell_o.inv    = fl4_q[3];
    cell_o.green  = fl4_q[2];
    cell_o.sx_neg = fl4_q[1];
    cell_o.sy_neg = fl4_q[0];
    cell_o.ux     = ux4_q;
    cell_o.uy     = uy4_q;
    cell_o.s2     = s2_4_q;
  end

endmodule

// File: design/hcsf_fifo.sv
`timescale 1ns / 1ps
module hcsf_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  hcsf_pkg::hcsf_cell_t    cell_i,
  input  logic                    pop_i,
  output hcsf_pkg::hcsf_cell_t    cell_o,
  output hcsf_pkg::hcsf_fifo_st_t st_o
);
  import hcsf_pkg::*;

  hcsf_cell_t mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;

  assign st_o.full  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign st_o.empty = (cnt_q == '0);
  assign cell_o     = mem_q[rd_q];
  assign cnt_d      = FIFO_CW'(cnt_q + FIFO_CW'(push_i) - FIFO_CW'(pop_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= FIFO_AW'(wr_q + 1'b1);
      if (pop_i)  rd_q <= FIFO_AW'(rd_q + 1'b1);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cell_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!st_o.full || pop_i))
    else $error("fifo push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !st_o.empty)
    else $error("fifo pop while empty");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CW'(FIFO_DEPTH))
    else $error("fifo count out of range");

endmodule

// File: design/hcsf_back.sv
`timescale 1ns / 1ps
module hcsf_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hcsf_pkg::hcsf_cell_t    cell_i,
  input  hcsf_pkg::hcsf_fifo_st_t fifo_st_i,
  output logic                    pop_o,
  input  logic [hcsf_pkg::CS_W-1:0] cs_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output hcsf_pkg::hcsf_out_t     out_o
);
  import hcsf_pkg::*;

  localparam int SL = SQ_STAGES - 1;
  localparam int DL = DIV_STAGES - 1;

  typedef struct packed {
    logic [SQ_IN_W-1:0] x;
    logic [ROOT_W-1:0]  root;
    logic [REM_W-1:0]   rem;
  } sq_t;

  typedef struct packed {
    logic             inv;
    logic             green;
    logic             dir;
    logic             sxn;
    logic             syn;
    logic [MAG_W-1:0] ux;
    logic [MAG_W-1:0] uy;
  } side_t;

  typedef struct packed {
    logic inv;
    logic green;
    logic dir;
    logic sxn;
    logic syn;
  } flag_t;

  typedef struct packed {
    logic [ROOT_W-1:0]  rem;
    logic [SLOPE_W-1:0] q;
    logic               sat;
  } sdiv_t;

  typedef struct packed {
    logic [NUM_W-1:0]    rem;
    logic [FALL_Q_W-1:0] q;
    logic                sat;
  } fdiv_t;

  function automatic sq_t sq_step(input sq_t s);
    sq_t o;
    logic [REM_W+1:0] rn, tr;
    rn  = {s.rem, s.x[SQ_IN_W-1 -: 2]};
    tr  = {(REM_W - ROOT_W)'(0), s.root, 2'b01};
    o.x = {s.x[SQ_IN_W-3:0], 2'b00};
    if (rn >= tr) begin
      o.rem  = REM_W'(rn - tr);
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = REM_W'(rn);
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sdiv_t s_step(input sdiv_t s, input logic [ROOT_W-1:0] d);
    sdiv_t o;
    o = s;
    if (s.rem >= d) begin
      o.rem = s.rem - d;
      o.q   = {s.q[SLOPE_W-2:0], 1'b1};
    end else begin
      o.q   = {s.q[SLOPE_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic fdiv_t f_step(input fdiv_t s, input logic [NUM_W-1:0] d);
    fdiv_t o;
    o = s;
    if (s.rem >= d) begin
      o.rem = s.rem - d;
      o.q   = {s.q[FALL_Q_W-2:0], 1'b1};
    end else begin
      o.q   = {s.q[FALL_Q_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [FALL_W-1:0] fall_fn(input fdiv_t s, input logic neg);
    logic [FALL_W-1:0] qf;
    qf = s.sat ? FALL_FULL : FALL_W'(s.q);
    if (neg) begin
      return qf[FALL_W-1] ? FALL_POS_MAX : qf;
    end
    return FALL_W'(~qf + FALL_W'(1));
  endfunction

  logic en;

  // entry stage
  logic              b0_v_q;
  hcsf_cell_t        b0_cell_q;
  logic [X1_W-1:0]   b0_x1_q;
  logic              b0_dir_q;
  logic [X1_W-1:0]   x1_d;
  logic [BIG_W-1:0]  big_d;
  logic [THR_W-1:0]  thr_d;
  logic              dir_d;

  // root stages
  logic [SQ_STAGES-1:0] sv_q;
  sq_t   sa_q [SQ_STAGES];
  sq_t   sb_q [SQ_STAGES];
  side_t ss_q [SQ_STAGES];

  // divide setup
  logic              de_v_q;
  sdiv_t             de_s_q;
  fdiv_t             de_x_q, de_y_q;
  logic [ROOT_W-1:0] de_r_q;
  flag_t             de_f_q;
  logic [NUM_W-1:0]  nx_d, ny_d, lim_d;

  // divide stages
  logic [DIV_STAGES-1:0] dv_q;
  sdiv_t             ds_q [DIV_STAGES];
  fdiv_t             dx_q [DIV_STAGES];
  fdiv_t             dy_q [DIV_STAGES];
  logic [ROOT_W-1:0] dr_q [DIV_STAGES];
  flag_t             df_q [DIV_STAGES];

  logic      out_v_q;
  hcsf_out_t out_q, out_d;

  assign en          = !out_v_q || out_ready_i;
  assign pop_o       = en && !fifo_st_i.empty;
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  assign x1_d = (X1_W'(cell_i.s2) << 9) + (X1_W'(cell_i.s2) << 6) + (X1_W'(cell_i.s2) << 5)
              + (X1_W'(cell_i.s2) << 4) + X1_W'(cell_i.s2);
  assign big_d = BIG_W'(cell_i.s2[DIR_LIM_W-1:0]) * BIG_W'(MICRO);
  assign thr_d = {(2 * CS_W)'((2 * CS_W)'(cs_i) * (2 * CS_W)'(cs_i)), 2'b00};
  assign dir_d = (cell_i.s2[SQR_W-1:DIR_LIM_W] != '0) || (BIG_W'(big_d) > BIG_W'(thr_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_v_q  <= 1'b0;
      sv_q    <= '0;
      de_v_q  <= 1'b0;
      dv_q    <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      b0_v_q  <= !fifo_st_i.empty;
      sv_q    <= {sv_q[SQ_STAGES-2:0], b0_v_q};
      de_v_q  <= sv_q[SL];
      dv_q    <= {dv_q[DIV_STAGES-2:0], de_v_q};
      out_v_q <= dv_q[DL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_cell_q <= cell_i;
      b0_x1_q   <= x1_d;
      b0_dir_q  <= dir_d;
    end
  end

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
    sq_t   a_in, b_in;
    side_t s_in;
    if (k == 0) begin : g_first
      assign a_in = '{x: SQ_IN_W'({b0_x1_q, X1_SH'(0)}), root: '0, rem: '0};
      assign b_in = '{x: SQ_IN_W'({b0_cell_q.s2, X2_SH'(0)}), root: '0, rem: '0};
      assign s_in = '{inv: b0_cell_q.inv, green: b0_cell_q.green, dir: b0_dir_q,
                      sxn: b0_cell_q.sx_neg, syn: b0_cell_q.sy_neg,
                      ux: b0_cell_q.ux, uy: b0_cell_q.uy};
    end else begin : g_next
      assign a_in = sa_q[k-1];
      assign b_in = sb_q[k-1];
      assign s_in = ss_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sa_q[k] <= sq_step(a_in);
        sb_q[k] <= sq_step(b_in);
        ss_q[k] <= s_in;
      end
    end
  end

  assign nx_d  = {ss_q[SL].ux, NUM_SH'(0)};
  assign ny_d  = {ss_q[SL].uy, NUM_SH'(0)};
  assign lim_d = {sb_q[SL].root, FALL_Q_W'(0)};

  always_ff @(posedge clk_i) begin
    if (en) begin
      de_s_q.rem <= sa_q[SL].root;
      de_s_q.q   <= '0;
      de_s_q.sat <= sa_q[SL].root[ROOT_W-1:SLOPE_W] >= (ROOT_W - SLOPE_W)'(cs_i);
      de_x_q.rem <= nx_d;
      de_x_q.q   <= '0;
      de_x_q.sat <= nx_d >= lim_d;
      de_y_q.rem <= ny_d;
      de_y_q.q   <= '0;
      de_y_q.sat <= ny_d >= lim_d;
      de_r_q     <= sb_q[SL].root;
      de_f_q     <= '{inv: ss_q[SL].inv, green: ss_q[SL].green, dir: ss_q[SL].dir,
                      sxn: ss_q[SL].sxn, syn: ss_q[SL].syn};
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    sdiv_t             s_in;
    fdiv_t             x_in, y_in;
    logic [ROOT_W-1:0] r_in;
    flag_t             f_in;
    fdiv_t             x_nx, y_nx;
    if (k == 0) begin : g_first
      assign s_in = de_s_q;
      assign x_in = de_x_q;
      assign y_in = de_y_q;
      assign r_in = de_r_q;
      assign f_in = de_f_q;
    end else begin : g_next
      assign s_in = ds_q[k-1];
      assign x_in = dx_q[k-1];
      assign y_in = dy_q[k-1];
      assign r_in = dr_q[k-1];
      assign f_in = df_q[k-1];
    end
    if (k < FALL_Q_W) begin : g_fall
      assign x_nx = f_step(x_in, NUM_W'(r_in) << (FALL_Q_W - 1 - k));
      assign y_nx = f_step(y_in, NUM_W'(r_in) << (FALL_Q_W - 1 - k));
    end else begin : g_hold
      assign x_nx = x_in;
      assign y_nx = y_in;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        ds_q[k] <= s_step(s_in, ROOT_W'(cs_i) << (SLOPE_W - 1 - k));
        dx_q[k] <= x_nx;
        dy_q[k] <= y_nx;
        dr_q[k] <= r_in;
        df_q[k] <= f_in;
      end
    end
  end

  always_comb begin
    out_d.in_green = !df_q[DL].inv && df_q[DL].green;
    out_d.has_dir  = !df_q[DL].inv && df_q[DL].dir;
    out_d.slope    = '0;
    out_d.fall_x   = '0;
    out_d.fall_y   = '0;
    if (!df_q[DL].inv) begin
      out_d.slope = ds_q[DL].sat ? SLOPE_MAX : ds_q[DL].q;
    end
    if (out_d.has_dir) begin
      out_d.fall_x = fall_fn(dx_q[DL], df_q[DL].sxn);
      out_d.fall_y = fall_fn(dy_q[DL], df_q[DL].syn);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  a_flat_no_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.has_dir) |-> (out_q.fall_x == '0 && out_q.fall_y == '0))
    else $error("fall vector set without direction");
  a_dir_slope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.has_dir) |-> (out_q.slope != '0))
    else $error("direction with zero slope");
  a_dir_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.has_dir) |-> (out_q.fall_x != '0 || out_q.fall_y != '0))
    else $error("direction with zero fall vector");

endmodule

// File: design/heightmap_cell_slope_and_fall_top.sv
`timescale 1ns / 1ps
// Heightmap cell slope and fall direction.
// s_axis: one word per grid cell. tdata bits 31:0 height_00, 63:32 height_10,
//   95:64 height_01, 127:96 height_11, 131:128 corner_invalid; tuser bit 0 in_green_in.
// m_axis: one word per cell, in order. tdata bits 23:0 slope_pct, 24 has_direction,
//   40:25 fall_x, 56:41 fall_y; tuser bit 0 in_green_out.
// cfg: cfg_data_i is cell_size, written whenever cfg_valid_i is high (cfg_ready_o is
//   always high); write it only while no cell is in flight. A zero acts as one.
// Throughput: one word per cycle while m_axis_tready is high, fully pipelined.
// From input accept to output valid a cell passes the front end, the queue, the
//   49-stage square root pipelines and the 24-stage restoring divide.
// A 4-word queue separates the gradient front end from the root/divide back end.
// When m_axis_tvalid is high and m_axis_tready is low the back end holds; the front
//   end keeps accepting until the queue fills, then s_axis_tready drops.
// Reset clears all valid state and sets cell_size to 1600.
module heightmap_cell_slope_and_fall_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [hcsf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // h00, h10, h01, h11, mask
  input  logic [0:0]                          s_axis_tuser,  // in_green_in
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [hcsf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // slope, has_dir, fx, fy
  output logic [0:0]                          m_axis_tuser,  // in_green_out
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hcsf_pkg::CS_W-1:0]           cfg_data_i
);
  import hcsf_pkg::*;

  logic [CS_W-1:0] cell_size_q, cs_eff;
  hcsf_in_t        in_s;
  hcsf_cell_t      f_cell, q_cell;
  hcsf_fifo_st_t   fifo_st;
  logic            push, pop;
  hcsf_out_t       res;

  assign cfg_ready_o = 1'b1;
  assign cs_eff      = (cell_size_q == '0) ? CS_W'(1) : cell_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= CS_RESET;
    end else if (cfg_valid_i) begin
      cell_size_q <= cfg_data_i;
    end
  end

  always_comb begin
    in_s.h00            = s_axis_tdata[31:0];
    in_s.h10            = s_axis_tdata[63:32];
    in_s.h01            = s_axis_tdata[95:64];
    in_s.h11            = s_axis_tdata[127:96];
    in_s.corner_invalid = s_axis_tdata[131:128];
    in_s.in_green       = s_axis_tuser[0];
  end

  hcsf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_i       (in_s),
    .fifo_st_i  (fifo_st),
    .push_o     (push),
    .cell_o     (f_cell)
  );

  hcsf_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cell_i (f_cell),
    .pop_i  (pop),
    .cell_o (q_cell),
    .st_o   (fifo_st)
  );

  hcsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cell_i      (q_cell),
    .fifo_st_i   (fifo_st),
    .pop_o       (pop),
    .cs_i        (cs_eff),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - OUT_USED_W)'(0), res.fall_y, res.fall_x,
                         res.has_dir, res.slope};
  assign m_axis_tuser = res.in_green;

endmodule

// File: tb/hcsf_cell_checker.sv
`timescale 1ns / 1ps
module hcsf_cell_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [hcsf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [0:0]                       s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [hcsf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [0:0]                       m_axis_tuser,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_o,
  input  logic [hcsf_pkg::CS_W-1:0]        cfg_data_i,
  output int                               pending_o,
  output int                               errors_o
);
  import hcsf_pkg::*;

  hcsf_out_t       expected_cells[$];
  logic [CS_W-1:0] cell_size_q;
  int              n_err;

  assign errors_o  = n_err;

  function automatic logic [63:0] isqrt(logic [127:0] x);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (128'(cand) * 128'(cand) <= x) res = cand;
    end
    return res;
  endfunction

  function automatic logic [FALL_W-1:0] unit_comp(longint s, logic [63:0] root);
    logic [127:0] mag;
    logic [127:0] q;
    longint       v;
    mag = 128'(s < 0 ? -s : s);
    q = (mag << 30) / 128'(root);
    if (q > 128'd32768) q = 128'd32768;
    v = (s < 0) ? longint'(q) : -longint'(q);
    if (v > 32767) v = 32767;
    return v[FALL_W-1:0];
  endfunction

  function automatic hcsf_out_t predict_cell(hcsf_in_t c, logic [CS_W-1:0] cs_reg);
    longint       h00, h10, h01, h11, sx, sy;
    logic [63:0]  ux, uy, slope, root;
    logic [127:0] s2, cs, big, thr;
    hcsf_out_t    o;
    o = '0;
    if (|c.corner_invalid) return o;
    h00 = c.h00;
    h10 = c.h10;
    h01 = c.h01;
    h11 = c.h11;
    cs = (cs_reg == 0) ? 128'd1 : 128'(cs_reg);
    o.in_green = c.in_green;
    sx = (h10 + h11) - (h00 + h01);
    sy = (h01 + h11) - (h00 + h10);
    ux = sx < 0 ? -sx : sx;
    uy = sy < 0 ? -sy : sy;
    s2 = 128'(ux) * 128'(ux) + 128'(uy) * 128'(uy);
    slope = 64'(128'(isqrt(s2 * 128'(12800 * 12800))) / cs);
    o.slope = (slope > 64'(SLOPE_MAX)) ? SLOPE_MAX : slope[SLOPE_W-1:0];
    big = s2 * 128'(1000000);
    thr = 128'd4 * cs * cs;
    if (big > thr) begin
      root = isqrt(s2 << 30);
      o.has_dir = 1'b1;
      o.fall_x = unit_comp(sx, root);
      o.fall_y = unit_comp(sy, root);
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hcsf_in_t  c;
    hcsf_out_t got, exp_o;
    if (!rst_ni) begin
      cell_size_q = CS_RESET;
      n_err = 0;
      expected_cells.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) cell_size_q = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        c.h00 = s_axis_tdata[31:0];
        c.h10 = s_axis_tdata[63:32];
        c.h01 = s_axis_tdata[95:64];
        c.h11 = s_axis_tdata[127:96];
        c.corner_invalid = s_axis_tdata[131:128];
        c.in_green = s_axis_tuser[0];
        expected_cells.push_back(predict_cell(c, cell_size_q));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.in_green = m_axis_tuser[0];
        got.slope = m_axis_tdata[23:0];
        got.has_dir = m_axis_tdata[24];
        got.fall_x = m_axis_tdata[40:25];
        got.fall_y = m_axis_tdata[56:41];
        if (expected_cells.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected word: %p", got);
        end else begin
          exp_o = expected_cells.pop_front();
          if (got !== exp_o) begin
            n_err++;
            if (n_err <= 10) $display("mismatch: expected %p actual %p", exp_o, got);
          end
        end
      end
    end
    pending_o = expected_cells.size();
  end
endmodule

// File: tb/heightmap_cell_slope_and_fall_top_test.sv
`timescale 1ns / 1ps
module heightmap_cell_slope_and_fall_top_test;
  import hcsf_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 120;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CS_W-1:0]        cfg_data_i = '0;

  int pending, errors, quiet_cycles;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  always #2 clk_i = ~clk_i;

  heightmap_cell_slope_and_fall_top u_top (.*);

  hcsf_cell_checker u_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .pending_o(pending), .errors_o(errors)
  );

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("heightmap_cell_slope_and_fall_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_cell(hcsf_in_t c);
    s_axis_tdata <= {4'b0, c.corner_invalid, c.h11, c.h01, c.h10, c.h00};
    s_axis_tuser <= c.in_green;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_cell_size(logic [CS_W-1:0] v);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic hcsf_in_t mk(int a, int b, int c, int d, logic [3:0] m, logic g);
    hcsf_in_t x;
    x.h00 = a;
    x.h10 = b;
    x.h01 = c;
    x.h11 = d;
    x.corner_invalid = m;
    x.in_green = g;
    return x;
  endfunction

  function automatic hcsf_in_t rand_cell();
    hcsf_in_t x;
    int base, span;
    x.corner_invalid = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'b0;
    x.in_green = 1'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        x.h00 = $urandom; x.h10 = $urandom; x.h01 = $urandom; x.h11 = $urandom;
      end
      default: begin
        base = $urandom;
        span = 1 << $urandom_range(0, 20);
        x.h00 = base + $signed($urandom_range(0, 2 * span)) - span;
        x.h10 = base + $signed($urandom_range(0, 2 * span)) - span;
        x.h01 = base + $signed($urandom_range(0, 2 * span)) - span;
        x.h11 = base + $signed($urandom_range(0, 2 * span)) - span;
      end
    endcase
    return x;
  endfunction

  logic [CS_W-1:0] sizes[5] = '{16'd1, 16'd65535, 16'd0, 16'd1600, 16'd37};

  initial begin
    localparam int MX = 32'h7fffffff;
    localparam int MN = 32'h80000000;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset cell size first
    send_cell(mk(MX, MX, MX, MX, 4'b0, 1'b1));
    send_cell(mk(MN, MN, MN, MN, 4'b0, 1'b1));
    send_cell(mk(MN, MX, MN, MX, 4'b0, 1'b1));
    send_cell(mk(MX, MN, MX, MN, 4'b0, 1'b0));
    send_cell(mk(MN, MN, MX, MX, 4'b0, 1'b1));
    send_cell(mk(MX, MX, MN, MN, 4'b0, 1'b1));
    send_cell(mk(MN, MX, MX, MX, 4'b0, 1'b1));
    send_cell(mk(0, 0, 0, 0, 4'b0, 1'b1));
    send_cell(mk(5, 5, 5, 5, 4'b0, 1'b0));
    send_cell(mk(0, 100, 0, 100, 4'b0, 1'b1));
    send_cell(mk(100, 0, 100, 0, 4'b0, 1'b1));
    send_cell(mk(0, 0, 100, 100, 4'b0, 1'b1));
    send_cell(mk(0, 1, 0, 1, 4'b0, 1'b1));
    send_cell(mk(0, 3, 0, 4, 4'b0, 1'b1));
    send_cell(mk(0, 1, 1, 0, 4'b0, 1'b1));
    send_cell(mk(MX, MX, MN, MN, 4'b0001, 1'b1));
    send_cell(mk(0, 100, 0, 100, 4'b0010, 1'b1));
    send_cell(mk(0, 100, 0, 100, 4'b0100, 1'b1));
    send_cell(mk(0, 100, 0, 100, 4'b1000, 1'b1));
    send_cell(mk(0, 100, 0, 100, 4'b1111, 1'b0));

    foreach (sizes[p]) begin
      write_cell_size(sizes[p]);
      if (p == 0) send_cell(mk(0, 1, 0, 1, 4'b0, 1'b1));
      if (p == 1) hold_req = 1'b1;
      if (p == $size(sizes) - 1) idle_on = 1'b0;
      for (int i = 0; i < 226; i++) begin
        if (p == 2 && i == 100) drain();
        send_cell(rand_cell());
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("heightmap_cell_slope_and_fall_top test passed");
    end else begin
      $display("heightmap_cell_slope_and_fall_top test failed");
    end
    $finish;
  end
endmodule
